### design/pafa_pkg.sv
// Shared constants, types and helper functions for the pair adhesion force accumulator.
// No dependencies; every other design file depends on this package.
package pafa_pkg;

    localparam int NUM_ATOMS = 1024;
    localparam int ADDR_W    = $clog2(NUM_ATOMS);
    localparam int ATOM_W    = 10;
    localparam int SEP_W     = 32;
    localparam int RAD_W     = 31;
    localparam int MASS_W    = 32;
    localparam int STR_W     = 32;
    localparam int FRC_W     = 48;
    localparam int MAG_W     = FRC_W - 1;
    localparam int FRAC_W    = 16;

    // iterative arithmetic widths
    localparam int OPD_W     = 48;
    localparam int CHUNK_W   = 16;
    localparam int NUM_CHUNK = OPD_W / CHUNK_W;
    localparam int PRD_W     = 2 * OPD_W;
    localparam int DIVN_W    = 48;
    localparam int DIVD_W    = 32;
    localparam int RSQ_W     = 64;
    localparam int ROOT_W    = RSQ_W / 2;
    localparam int RSUM_W    = RAD_W + 1;
    localparam int MSUM_W    = MASS_W + 1;
    localparam int U_W       = FRAC_W + 1;

    localparam logic [MAG_W-1:0]        FMAX    = '1;
    localparam logic signed [FRC_W-1:0] FRC_POS = {1'b0, FMAX};
    localparam logic signed [FRC_W-1:0] FRC_NEG = ~FRC_POS;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int MODEL_W    = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FORCE_MODEL = 2'd0,
        CFG_STRENGTH    = 2'd1,
        CFG_NEWTON_MODE = 2'd2
    } cfg_reg_t;

    localparam logic [MODEL_W-1:0] MODEL_SPRING   = 2'd1;
    localparam logic [MODEL_W-1:0] MODEL_ADHESION = 2'd2;

    localparam logic REQ_PAIR = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef struct packed {
        logic [MODEL_W-1:0] force_model;
        logic [STR_W-1:0]   strength;
        logic               newton_mode;
    } pafa_cfg_t;

    typedef struct packed {
        logic                      is_read;
        logic [ATOM_W-1:0]         ia;
        logic [ATOM_W-1:0]         ja;
        logic                      apply_j;
        logic signed [FRC_W-1:0]   fx;
        logic signed [FRC_W-1:0]   fy;
        logic signed [FRC_W-1:0]   fz;
    } pafa_cmd_t;

    // min(floor(p / 2^16), FMAX)
    function automatic logic [MAG_W-1:0] sat_q16(input logic [PRD_W-1:0] p);
        if (p[PRD_W-1:FRAC_W+MAG_W] != '0)
            return FMAX;
        return p[FRAC_W+MAG_W-1:FRAC_W];
    endfunction

    function automatic logic signed [FRC_W-1:0] sat_add(input logic signed [FRC_W-1:0] a,
                                                        input logic signed [FRC_W-1:0] b);
        logic [FRC_W:0] s;
        s = {a[FRC_W-1], a} + {b[FRC_W-1], b};
        if (s[FRC_W] != s[FRC_W-1])
            return s[FRC_W] ? FRC_NEG : FRC_POS;
        return s[FRC_W-1:0];
    endfunction

    function automatic logic in_range(input logic [ATOM_W-1:0] idx);
        return int'(idx) < NUM_ATOMS;
    endfunction

endpackage

### design/pafa_if.sv
// Valid/ready channel interfaces for pair requests and force read results.
// Depends on pafa_pkg for field widths.
interface pafa_req_if;
    logic                                valid;
    logic                                ready;
    logic                                req_type;
    logic [pafa_pkg::ATOM_W-1:0]         first_atom;
    logic [pafa_pkg::ATOM_W-1:0]         second_atom;
    logic                                second_owned;
    logic signed [pafa_pkg::SEP_W-1:0]   sep_x;
    logic signed [pafa_pkg::SEP_W-1:0]   sep_y;
    logic signed [pafa_pkg::SEP_W-1:0]   sep_z;
    logic [pafa_pkg::RAD_W-1:0]          radius_first;
    logic [pafa_pkg::RAD_W-1:0]          radius_second;
    logic [pafa_pkg::MASS_W-1:0]         mass_first;
    logic [pafa_pkg::MASS_W-1:0]         mass_second;

    modport source (output valid, req_type, first_atom, second_atom, second_owned,
                    sep_x, sep_y, sep_z, radius_first, radius_second,
                    mass_first, mass_second, input ready);
    modport sink   (input valid, req_type, first_atom, second_atom, second_owned,
                    sep_x, sep_y, sep_z, radius_first, radius_second,
                    mass_first, mass_second, output ready);
endinterface

interface pafa_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [pafa_pkg::ATOM_W-1:0]         atom_index;
    logic signed [pafa_pkg::FRC_W-1:0]   force_x;
    logic signed [pafa_pkg::FRC_W-1:0]   force_y;
    logic signed [pafa_pkg::FRC_W-1:0]   force_z;

    modport source (output valid, atom_index, force_x, force_y, force_z, input ready);
    modport sink   (input valid, atom_index, force_x, force_y, force_z, output ready);
endinterface

### design/pafa_mul.sv
// Iterative 48x48 multiplier: one 48x16 partial product per cycle.
// Depends on pafa_pkg.
module pafa_mul (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [pafa_pkg::OPD_W-1:0]    a,
    input  logic [pafa_pkg::OPD_W-1:0]    b,
    output logic                          done,
    output logic [pafa_pkg::PRD_W-1:0]    prod
);
    import pafa_pkg::*;

    localparam int CNT_W = $clog2(NUM_CHUNK);

    logic                        busy_reg;
    logic                        done_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [OPD_W-1:0]            a_reg;
    logic [OPD_W-1:0]            b_reg;
    logic [PRD_W-1:0]            acc_reg;
    logic [OPD_W+CHUNK_W-1:0]    pp;

    assign pp   = a_reg * b_reg[OPD_W-1 -: CHUNK_W];
    assign done = done_reg;
    assign prod = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_CHUNK - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // high chunk first: shift the running sum up and add the next partial product
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            b_reg   <= {b_reg[OPD_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}};
            acc_reg <= {acc_reg[PRD_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}} + PRD_W'(pp);
        end
    end

endmodule

### design/pafa_div.sv
// Restoring divider, one quotient bit per cycle: 48-bit dividend, 32-bit divisor.
// Depends on pafa_pkg.
module pafa_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [pafa_pkg::DIVN_W-1:0]   num,
    input  logic [pafa_pkg::DIVD_W-1:0]   den,
    output logic                          done,
    output logic [pafa_pkg::DIVN_W-1:0]   quo
);
    import pafa_pkg::*;

    localparam int CNT_W = $clog2(DIVN_W);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [DIVN_W-1:0]     quo_reg;
    logic [DIVD_W-1:0]     rem_reg;
    logic [DIVD_W-1:0]     den_reg;
    logic [DIVD_W:0]       trial;
    logic                  fits;

    assign trial = {rem_reg, quo_reg[DIVN_W-1]};
    assign fits  = trial >= {1'b0, den_reg};
    assign done  = done_reg;
    assign quo   = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIVN_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIVN_W-2:0], fits};
            rem_reg <= fits ? DIVD_W'(trial - {1'b0, den_reg}) : trial[DIVD_W-1:0];
        end
    end

endmodule

### design/pafa_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle: 64-bit in, 32-bit floor root.
// Depends on pafa_pkg.
module pafa_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [pafa_pkg::RSQ_W-1:0]    value,
    output logic                          done,
    output logic [pafa_pkg::ROOT_W-1:0]   root
);
    import pafa_pkg::*;

    localparam int CNT_W = $clog2(ROOT_W);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [RSQ_W-1:0]      val_reg;
    logic [ROOT_W:0]       rem_reg;
    logic [ROOT_W-1:0]     root_reg;
    logic [ROOT_W+1:0]     rem_sh;
    logic [ROOT_W+1:0]     trial;
    logic                  fits;

    assign rem_sh = {rem_reg[ROOT_W-1:0], val_reg[RSQ_W-1 -: 2]};
    assign trial  = {root_reg, 2'b01};
    assign fits   = rem_sh >= trial;
    assign done   = done_reg;
    assign root   = root_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ROOT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg  <= value;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            val_reg  <= {val_reg[RSQ_W-3:0], 2'b00};
            rem_reg  <= fits ? (ROOT_W+1)'(rem_sh - trial) : rem_sh[ROOT_W:0];
            root_reg <= {root_reg[ROOT_W-2:0], fits};
        end
    end

endmodule

### design/pafa_engine.sv
// Force sequencer: takes request beats, derives the pair force on shared iterative units,
// and hands update or read commands to the force store. Depends on pafa_pkg, pafa_if,
// pafa_mul, pafa_div, pafa_sqrt.
module pafa_engine (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pafa_pkg::pafa_cfg_t   cfg,
    input  logic                  store_clearing,
    pafa_req_if.sink              req,
    output logic                  cmd_valid,
    input  logic                  cmd_ready,
    output pafa_pkg::pafa_cmd_t   cmd
);
    import pafa_pkg::*;

    typedef enum logic [12:0] {
        E_IDLE   = 13'b0000000000001,
        E_SQ     = 13'b0000000000010,
        E_SQRT   = 13'b0000000000100,
        E_PROD   = 13'b0000000001000,
        E_CHECK  = 13'b0000000010000,
        E_MK     = 13'b0000000100000,
        E_SPRING = 13'b0000001000000,
        E_DIVQ   = 13'b0000010000000,
        E_QT     = 13'b0000100000000,
        E_QMAG   = 13'b0001000000000,
        E_DIVU   = 13'b0010000000000,
        E_COMP   = 13'b0100000000000,
        E_ISSUE  = 13'b1000000000000
    } eng_state_t;

    eng_state_t                state_reg, state_next;
    logic                      launch_reg, launch_next;
    logic [1:0]                axis_reg, axis_next;

    logic                      is_read_reg;
    logic [ATOM_W-1:0]         ia_reg;
    logic [ATOM_W-1:0]         ja_reg;
    logic                      apply_j_reg;
    logic [MODEL_W-1:0]        model_reg;
    logic [SEP_W-1:0]          adx_reg [3];
    logic                      sgn_reg [3];
    logic [RSUM_W-1:0]         rsum_reg;
    logic [MSUM_W-1:0]         msum_reg;
    logic [RSQ_W-1:0]          rsq_reg;
    logic [ROOT_W-1:0]         r_reg;
    logic [RSQ_W-1:0]          p_reg;
    logic [MAG_W-1:0]          mk_reg;
    logic [MAG_W-1:0]          mag_reg;
    logic [DIVN_W-1:0]         q_reg;
    logic [U_W-1:0]            u_reg;
    logic                      neg_reg;
    logic signed [FRC_W-1:0]   f_reg [3];

    logic                      mul_start, mul_done;
    logic [OPD_W-1:0]          mul_a, mul_b;
    logic [PRD_W-1:0]          mul_prod;
    logic                      div_start, div_done;
    logic [DIVN_W-1:0]         div_num, div_quo;
    logic [DIVD_W-1:0]         div_den;
    logic                      sqrt_start, sqrt_done;
    logic [ROOT_W-1:0]         sqrt_root;

    logic                      accept;
    logic [ROOT_W-1:0]         spring_ad;
    logic                      active;
    logic [MAG_W-1:0]          comp_mag;

    function automatic logic [SEP_W-1:0] abs_sep(input logic signed [SEP_W-1:0] d);
        return d[SEP_W-1] ? (~d + 1'b1) : d;
    endfunction

    assign req.ready = (state_reg == E_IDLE) && !store_clearing;
    assign accept    = req.valid && req.ready;
    assign spring_ad = (r_reg < rsum_reg) ? (rsum_reg - r_reg) : (r_reg - rsum_reg);
    assign comp_mag  = sat_q16(mul_prod);

    always_comb
    begin
        active = 1'b0;
        if (model_reg == MODEL_SPRING)
            active = {1'b0, r_reg} < {rsum_reg, 1'b0};
        else if (model_reg == MODEL_ADHESION)
            active = (rsq_reg > RSQ_W'({rsum_reg, {FRAC_W{1'b0}}}))
                  && ({2'b00, rsq_reg} < {p_reg, 2'b00});
        if (rsq_reg == '0)
            active = 1'b0;
    end

    // operand steering for the shared units
    always_comb
    begin
        mul_start  = 1'b0;
        div_start  = 1'b0;
        sqrt_start = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        div_num    = '0;
        div_den    = r_reg;
        case (state_reg)
            E_SQ:
            begin
                mul_start = launch_reg;
                mul_a     = OPD_W'(adx_reg[axis_reg]);
                mul_b     = OPD_W'(adx_reg[axis_reg]);
            end
            E_SQRT:   sqrt_start = launch_reg;
            E_PROD:
            begin
                mul_start = launch_reg;
                mul_a     = OPD_W'(rsum_reg);
                mul_b     = OPD_W'(cfg.strength);
            end
            E_MK:
            begin
                mul_start = launch_reg;
                mul_a     = OPD_W'(msum_reg);
                mul_b     = OPD_W'(cfg.strength);
            end
            E_SPRING:
            begin
                mul_start = launch_reg;
                mul_a     = OPD_W'(mk_reg);
                mul_b     = OPD_W'(spring_ad);
            end
            E_DIVQ:
            begin
                div_start = launch_reg;
                div_num   = DIVN_W'({rsum_reg, {FRAC_W{1'b0}}});
            end
            E_QT:
            begin
                mul_start = launch_reg;
                mul_a     = OPD_W'(mk_reg);
                mul_b     = q_reg;
            end
            E_QMAG:
            begin
                mul_start = launch_reg;
                mul_a     = OPD_W'(mag_reg);
                mul_b     = q_reg;
            end
            E_DIVU:
            begin
                div_start = launch_reg;
                div_num   = DIVN_W'({adx_reg[axis_reg], {FRAC_W{1'b0}}});
            end
            E_COMP:
            begin
                mul_start = launch_reg;
                mul_a     = OPD_W'(mag_reg);
                mul_b     = OPD_W'(u_reg);
            end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        launch_next = 1'b0;
        axis_next   = axis_reg;
        case (state_reg)
            E_IDLE:
            begin
                if (accept)
                begin
                    if (req.req_type == REQ_READ)
                        state_next = E_ISSUE;
                    else if (cfg.force_model == MODEL_SPRING
                             || cfg.force_model == MODEL_ADHESION)
                    begin
                        state_next  = E_SQ;
                        launch_next = 1'b1;
                        axis_next   = '0;
                    end
                end
            end
            E_SQ:
            begin
                if (mul_done)
                begin
                    launch_next = 1'b1;
                    if (axis_reg == 2'd2)
                    begin
                        state_next = E_SQRT;
                        axis_next  = '0;
                    end
                    else
                        axis_next = axis_reg + 1'b1;
                end
            end
            E_SQRT:
            begin
                if (sqrt_done)
                begin
                    if (model_reg == MODEL_ADHESION)
                    begin
                        state_next  = E_PROD;
                        launch_next = 1'b1;
                    end
                    else
                        state_next = E_CHECK;
                end
            end
            E_PROD:
            begin
                if (mul_done)
                    state_next = E_CHECK;
            end
            E_CHECK:
            begin
                if (active)
                begin
                    state_next  = E_MK;
                    launch_next = 1'b1;
                end
                else
                    state_next = E_IDLE;
            end
            E_MK:
            begin
                if (mul_done)
                begin
                    launch_next = 1'b1;
                    state_next  = (model_reg == MODEL_SPRING) ? E_SPRING : E_DIVQ;
                end
            end
            E_SPRING:
            begin
                if (mul_done)
                begin
                    state_next  = E_DIVU;
                    launch_next = 1'b1;
                    axis_next   = '0;
                end
            end
            E_DIVQ:
            begin
                if (div_done)
                begin
                    state_next  = E_QT;
                    launch_next = 1'b1;
                end
            end
            E_QT:
            begin
                if (mul_done)
                begin
                    state_next  = E_QMAG;
                    launch_next = 1'b1;
                end
            end
            E_QMAG:
            begin
                if (mul_done)
                begin
                    state_next  = E_DIVU;
                    launch_next = 1'b1;
                    axis_next   = '0;
                end
            end
            E_DIVU:
            begin
                if (div_done)
                begin
                    state_next  = E_COMP;
                    launch_next = 1'b1;
                end
            end
            E_COMP:
            begin
                if (mul_done)
                begin
                    if (axis_reg == 2'd2)
                        state_next = E_ISSUE;
                    else
                    begin
                        state_next  = E_DIVU;
                        launch_next = 1'b1;
                        axis_next   = axis_reg + 1'b1;
                    end
                end
            end
            E_ISSUE:
            begin
                if (cmd_ready)
                    state_next = E_IDLE;
            end
            default: state_next = E_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= E_IDLE;
            launch_reg <= 1'b0;
            axis_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= launch_next;
            axis_reg   <= axis_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            is_read_reg <= req.req_type;
            ia_reg      <= req.first_atom;
            ja_reg      <= req.second_atom;
            apply_j_reg <= cfg.newton_mode | req.second_owned;
            model_reg   <= cfg.force_model;
            adx_reg[0]  <= abs_sep(req.sep_x);
            adx_reg[1]  <= abs_sep(req.sep_y);
            adx_reg[2]  <= abs_sep(req.sep_z);
            sgn_reg[0]  <= req.sep_x[SEP_W-1];
            sgn_reg[1]  <= req.sep_y[SEP_W-1];
            sgn_reg[2]  <= req.sep_z[SEP_W-1];
            rsum_reg    <= {1'b0, req.radius_first} + {1'b0, req.radius_second};
            msum_reg    <= {1'b0, req.mass_first} + {1'b0, req.mass_second};
            rsq_reg     <= '0;
        end
        if (state_reg == E_SQ && mul_done)
            rsq_reg <= rsq_reg + mul_prod[RSQ_W-1:0];
        if (sqrt_done)
            r_reg <= sqrt_root;
        if (state_reg == E_PROD && mul_done)
            p_reg <= mul_prod[RSQ_W-1:0];
        if (state_reg == E_MK && mul_done)
        begin
            mk_reg  <= comp_mag;
            neg_reg <= (model_reg == MODEL_ADHESION) || (r_reg >= rsum_reg);
        end
        if ((state_reg == E_SPRING || state_reg == E_QT || state_reg == E_QMAG) && mul_done)
            mag_reg <= comp_mag;
        if (state_reg == E_DIVQ && div_done)
            q_reg <= div_quo;
        if (state_reg == E_DIVU && div_done)
            u_reg <= div_quo[U_W-1:0];
        if (state_reg == E_COMP && mul_done)
            f_reg[axis_reg] <= (neg_reg ^ sgn_reg[axis_reg]) ? -{1'b0, comp_mag}
                                                             : {1'b0, comp_mag};
    end

    assign cmd_valid   = (state_reg == E_ISSUE);
    assign cmd.is_read = is_read_reg;
    assign cmd.ia      = ia_reg;
    assign cmd.ja      = ja_reg;
    assign cmd.apply_j = apply_j_reg;
    assign cmd.fx      = f_reg[0];
    assign cmd.fy      = f_reg[1];
    assign cmd.fz      = f_reg[2];

    pafa_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    pafa_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    pafa_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .value (rsq_reg),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (div_den != '0))
        else $error("divider launched with zero separation length");

    a_force_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd.is_read) |-> (cmd.fx != FRC_NEG && cmd.fy != FRC_NEG
                                         && cmd.fz != FRC_NEG))
        else $error("pair force component outside the symmetric saturation range");

endmodule

### design/pafa_store.sv
// Force store: one synchronous memory holding x/y/z force per particle, updated by
// read-modify-write, with a clearing pass after reset and a registered result beat.
// Depends on pafa_pkg and pafa_if.
module pafa_store (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  pafa_pkg::pafa_cmd_t   cmd,
    output logic                  clearing,
    pafa_rsp_if.source            rsp
);
    import pafa_pkg::*;

    localparam int ENT_W = 3 * FRC_W;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_RD_I  = 6'b000100,
        S_WR_I  = 6'b001000,
        S_RD_J  = 6'b010000,
        S_WR_J  = 6'b100000
    } st_state_t;

    st_state_t                 state_reg, state_next;
    logic [ADDR_W-1:0]         clr_cnt_reg;
    pafa_cmd_t                 cmd_reg;
    logic [ENT_W-1:0]          mem [NUM_ATOMS];
    logic [ENT_W-1:0]          rdata_reg;

    logic                      mem_we, mem_re;
    logic [ADDR_W-1:0]         mem_waddr, mem_raddr;
    logic [ENT_W-1:0]          mem_wdata;

    logic                      out_valid_reg;
    logic [ATOM_W-1:0]         out_idx_reg;
    logic signed [FRC_W-1:0]   out_fx_reg, out_fy_reg, out_fz_reg;
    logic                      out_load;
    logic                      out_free;
    logic                      i_ok, j_ok;

    logic signed [FRC_W-1:0]   old_x, old_y, old_z;

    assign old_x    = rdata_reg[ENT_W-1 -: FRC_W];
    assign old_y    = rdata_reg[2*FRC_W-1 -: FRC_W];
    assign old_z    = rdata_reg[FRC_W-1:0];
    assign i_ok     = in_range(cmd_reg.ia);
    assign j_ok     = in_range(cmd_reg.ja);
    assign out_free = !out_valid_reg || rsp.ready;
    assign clearing = (state_reg == S_CLEAR);
    assign cmd_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_waddr  = ADDR_W'(cmd_reg.ia);
        mem_raddr  = ADDR_W'(cmd_reg.ia);
        mem_wdata  = '0;
        out_load   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                if (clr_cnt_reg == ADDR_W'(NUM_ATOMS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (cmd_valid)
                    state_next = S_RD_I;
            end
            S_RD_I:
            begin
                mem_re     = 1'b1;
                state_next = S_WR_I;
            end
            S_WR_I:
            begin
                if (cmd_reg.is_read)
                begin
                    // hold until the result register can take the beat
                    if (out_free)
                    begin
                        out_load   = 1'b1;
                        mem_we     = i_ok;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    mem_we     = i_ok;
                    mem_wdata  = {sat_add(old_x, cmd_reg.fx), sat_add(old_y, cmd_reg.fy),
                                  sat_add(old_z, cmd_reg.fz)};
                    state_next = (cmd_reg.apply_j && j_ok) ? S_RD_J : S_IDLE;
                end
            end
            S_RD_J:
            begin
                // the write of i landed last edge, so a same-particle pair sees it here
                mem_re     = 1'b1;
                mem_raddr  = ADDR_W'(cmd_reg.ja);
                state_next = S_WR_J;
            end
            S_WR_J:
            begin
                mem_we     = 1'b1;
                mem_waddr  = ADDR_W'(cmd_reg.ja);
                mem_wdata  = {sat_add(old_x, -cmd_reg.fx), sat_add(old_y, -cmd_reg.fy),
                              sat_add(old_z, -cmd_reg.fz)};
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
            cmd_reg <= cmd;
        if (out_load)
        begin
            out_idx_reg <= cmd_reg.ia;
            out_fx_reg  <= i_ok ? old_x : '0;
            out_fy_reg  <= i_ok ? old_y : '0;
            out_fz_reg  <= i_ok ? old_z : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= mem[mem_raddr];
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.atom_index = out_idx_reg;
    assign rsp.force_x    = out_fx_reg;
    assign rsp.force_y    = out_fy_reg;
    assign rsp.force_z    = out_fz_reg;

    a_no_cmd_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !cmd_ready)
        else $error("command taken during the clearing pass");

    a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || rsp.ready))
        else $error("result register overwritten before its beat was taken");

endmodule

### design/pair_adhesion_force_accumulator_top.sv
// Top level of the pair adhesion force accumulator: configuration registers, force
// sequencer and force store. Depends on pafa_pkg, pafa_if, pafa_engine, pafa_store.
//
// Each request beat is either a neighbor pair (req_type 0) or a read-and-clear of one
// particle's force (req_type 1). A pair is turned into a central force in Q32.16 -- a
// linear overlap spring or an inverse-square adhesion, picked by force_model -- which
// is added to particle first_atom and, when newton_mode is set or the neighbor is owned,
// subtracted from second_atom, saturating to 48 bits. Pairs give no result beat; a
// read gives exactly one on rsp. Work is one item at a time: a pair holds the sequencer
// through the bit-serial divider (three divides for the direction cosines plus one
// more for adhesion), the square root and the multiplier. A pair outside its window
// drops out after the square root (for adhesion, after the product) with no command;
// a pair with an unknown model is dropped at the beat itself, so the next beat can
// follow on the next cycle. A read goes from the sequencer's issue state to the store's
// read state and its write state, which waits for a free result register and loads it.
// The store's read-modify-write uses a read state and a write state per entry, one entry
// or two, and runs alongside the sequencer's next item. After reset the store runs a
// clearing pass over all NUM_ATOMS (1024) entries during which req.ready stays low. A
// finished read beat sits in an output register, so the next request is taken while it
// waits. The user must write configuration through cfg_we/cfg_index/cfg_data only
// while the block is idle; the block itself does not enforce this.
module pair_adhesion_force_accumulator_top (
    input  logic                              clk,
    input  logic                              rst_n,
    pafa_req_if.sink                          req,
    pafa_rsp_if.source                        rsp,
    input  logic                              cfg_we,
    input  logic [pafa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pafa_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import pafa_pkg::*;

    pafa_cfg_t   cfg_reg;
    logic        cmd_valid;
    logic        cmd_ready;
    pafa_cmd_t   cmd;
    logic        store_clearing;

    // configuration registers; an index past the list is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.force_model <= MODEL_SPRING;
            cfg_reg.strength    <= STR_W'(1 << FRAC_W);
            cfg_reg.newton_mode <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FORCE_MODEL: cfg_reg.force_model <= cfg_data[MODEL_W-1:0];
                CFG_STRENGTH:    cfg_reg.strength    <= cfg_data[STR_W-1:0];
                CFG_NEWTON_MODE: cfg_reg.newton_mode <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // sequencer: accepts request beats and computes the pair force
    pafa_engine u_engine (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .store_clearing (store_clearing),
        .req            (req),
        .cmd_valid      (cmd_valid),
        .cmd_ready      (cmd_ready),
        .cmd            (cmd)
    );

    // force memory with read-modify-write and the result register
    pafa_store u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .clearing  (store_clearing),
        .rsp       (rsp)
    );

endmodule
